FILE: hdl/tlp3_pkg.sv
// Package for the trilinear prolongation unit: sizes, command codes,
// weights and the padded-grid address function. Used by every file in hdl.
`timescale 1ns / 1ps

package tlp3_pkg;

  // Grid geometry. The interior side is fixed, with one ghost layer each side.
  localparam int COARSE_SIDE = 32;
  localparam int PADDED_SIDE = COARSE_SIDE + 2;
  localparam int STORE_DEPTH = PADDED_SIDE * PADDED_SIDE * PADDED_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int COORD_W     = 6;
  localparam int SIZE_W      = 6;
  localparam int VALUE_WIDTH = 32;
  localparam int MASK_W      = 8;
  localparam int WEIGHT_W    = 5;
  localparam int SHIFT_W     = 6;                      // divide by 64
  localparam int ACC_W       = VALUE_WIDTH + SHIFT_W;  // 64 x full scale fits

  // Neighbor weights, indexed by how many axes step off the center.
  localparam logic [WEIGHT_W-1:0] W_CENTER = WEIGHT_W'(27);
  localparam logic [WEIGHT_W-1:0] W_FACE   = WEIGHT_W'(9);
  localparam logic [WEIGHT_W-1:0] W_EDGE   = WEIGHT_W'(3);
  localparam logic [WEIGHT_W-1:0] W_CORNER = WEIGHT_W'(1);

  typedef enum logic [1:0] {
    CMD_LOAD_VALUE = 2'd0,
    CMD_LOAD_MASK  = 2'd1,
    CMD_PROLONG    = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic                clear;   // zero the accumulator
    logic                valid;   // read data of this cycle is a term
    logic [WEIGHT_W-1:0] weight;  // weight of that term
  } mac_ctrl_t;

  // Weight of the term at a given step: each set bit moves one axis over.
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [2:0] step);
    logic [1:0] n;
    n = 2'(step[0]) + 2'(step[1]) + 2'(step[2]);
    unique case (n)
      2'd0:    weight_of = W_CENTER;
      2'd1:    weight_of = W_FACE;
      2'd2:    weight_of = W_EDGE;
      default: weight_of = W_CORNER;
    endcase
  endfunction

  // Linear address of a padded-grid cell, x major and z minor.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    logic [ADDR_W-1:0] row;
    row       = ADDR_W'(x) * ADDR_W'(PADDED_SIDE) + ADDR_W'(y);
    cell_addr = row * ADDR_W'(PADDED_SIDE) + ADDR_W'(z);
  endfunction

  // A size register above the interior side acts as the side.
  function automatic logic [SIZE_W:0] eff_size(input logic [SIZE_W-1:0] s);
    if ((SIZE_W + 1)'(s) > (SIZE_W + 1)'(COARSE_SIDE)) begin
      eff_size = (SIZE_W + 1)'(COARSE_SIDE);
    end else begin
      eff_size = (SIZE_W + 1)'(s);
    end
  endfunction

endpackage

FILE: hdl/tlp3_mac.sv
// Shared multiply-accumulate unit of the prolongation datapath, with the
// final floor shift and saturating add. Depends on tlp3_pkg.
`timescale 1ns / 1ps

module tlp3_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tlp3_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [tlp3_pkg::VALUE_WIDTH-1:0] data_i,
  input  logic signed [tlp3_pkg::VALUE_WIDTH-1:0] fine_i,
  output logic signed [tlp3_pkg::VALUE_WIDTH-1:0] result_o
);

  localparam int VW = tlp3_pkg::VALUE_WIDTH;
  localparam int AW = tlp3_pkg::ACC_W;

  logic signed [AW-1:0] prod_d, prod_q;
  logic                 prod_vld_q;
  logic signed [AW-1:0] acc_q;
  logic signed [VW-1:0] quot;
  logic signed [VW:0]   total;

  // One term: read word times a small unsigned weight, both widened to the
  // accumulator width first so that the product cannot wrap.
  assign prod_d = $signed({{(AW-VW){data_i[VW-1]}}, data_i}) *
                  $signed({{(AW-tlp3_pkg::WEIGHT_W){1'b0}}, ctrl_i.weight});

  // Product register, then accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.valid & ~ctrl_i.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // Dropping the six low bits of the sum is the floor divide by 64.
  assign quot  = acc_q[AW-1:tlp3_pkg::SHIFT_W];
  assign total = {fine_i[VW-1], fine_i} + {quot[VW-1], quot};

  // Saturate when the two top bits of the sum disagree.
  always_comb begin
    if (total[VW] != total[VW-1]) begin
      result_o = total[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      result_o = total[VW-1:0];
    end
  end

endmodule

FILE: hdl/trilinear_prolongation_3d_unit.sv
// Top level of the trilinear prolongation unit: command sequencer, coarse
// and mask memories, size registers. Depends on tlp3_pkg and tlp3_mac.
`timescale 1ns / 1ps

// Commands are taken when start is high and busy is low. A load of a coarse
// value or of a mask byte is written, and its done strobe registered, in the
// decode state. A prolong decodes, makes eight reads of the single-port
// coarse memory at one read per cycle, and registers read data, product and
// accumulator before the saturated result is registered. Each result is shown
// for exactly one cycle with done_o; the receiver cannot stall, and the next
// command may be started in that same cycle. Memories are not cleared: every
// coarse entry and mask byte must be loaded before a prolong reads it. Size
// registers must be written only while idle; the block does not enforce it.
module trilinear_prolongation_3d_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Command channel.
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            command_i,
  input  logic [tlp3_pkg::COORD_W-1:0]          cell_x_i,
  input  logic [tlp3_pkg::COORD_W-1:0]          cell_y_i,
  input  logic [tlp3_pkg::COORD_W-1:0]          cell_z_i,
  input  logic [2:0]                            octant_i,
  input  logic signed [tlp3_pkg::VALUE_WIDTH-1:0] sample_i,
  input  logic [tlp3_pkg::MASK_W-1:0]           mask_bits_i,
  // Result channel.
  output logic                                  done_o,
  output logic signed [tlp3_pkg::VALUE_WIDTH-1:0] fine_result_o,
  output logic                                  status_o,
  // Configuration channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_index_i,
  input  logic [tlp3_pkg::SIZE_W-1:0]           cfg_data_i
);

  localparam int VW = tlp3_pkg::VALUE_WIDTH;
  localparam int CW = tlp3_pkg::COORD_W;
  localparam int SW = tlp3_pkg::SIZE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ
  } state_e;

  localparam logic [3:0] LAST_STEP = 4'd10;

  state_e                          state_q;
  logic [3:0]                      step_q;
  logic                            done_q;
  logic signed [VW-1:0]            result_q;
  logic                            status_q;
  logic [SW-1:0]                   size_x_q, size_y_q, size_z_q;

  // Latched command word.
  tlp3_pkg::cmd_e                  cmd_q;
  logic [CW-1:0]                   x_q, y_q, z_q;
  logic [2:0]                      oct_q;
  logic signed [VW-1:0]            sample_q;
  logic [tlp3_pkg::MASK_W-1:0]     mbits_q;

  // Memories and their ports.
  logic signed [VW-1:0]            coarse_mem [tlp3_pkg::STORE_DEPTH];
  logic [tlp3_pkg::MASK_W-1:0]     mask_mem   [tlp3_pkg::STORE_DEPTH];
  logic signed [VW-1:0]            coarse_rd_q;
  logic [tlp3_pkg::MASK_W-1:0]     mask_rd_q;
  logic [tlp3_pkg::ADDR_W-1:0]     addr;
  logic                            coarse_we, mask_we, coarse_re, mask_re;
  logic                            rd_vld_q;
  logic [tlp3_pkg::WEIGHT_W-1:0]   rd_weight_q;

  logic [SW:0]                     sx, sy, sz;
  logic                            load_oob, prolong_oob;
  logic [CW-1:0]                   ax, ay, az;
  logic                            issue;
  tlp3_pkg::mac_ctrl_t             mac_ctrl;
  logic signed [VW-1:0]            mac_result;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign fine_result_o = result_q;
  assign status_o    = status_q;

  // Range checks against the effective sizes.
  assign sx = tlp3_pkg::eff_size(size_x_q);
  assign sy = tlp3_pkg::eff_size(size_y_q);
  assign sz = tlp3_pkg::eff_size(size_z_q);

  assign load_oob = ((SW + 1)'(x_q) > sx + 1'b1) || ((SW + 1)'(y_q) > sy + 1'b1) ||
                    ((SW + 1)'(z_q) > sz + 1'b1);
  assign prolong_oob = (x_q == '0) || ((SW + 1)'(x_q) > sx) ||
                       (y_q == '0) || ((SW + 1)'(y_q) > sy) ||
                       (z_q == '0) || ((SW + 1)'(z_q) > sz);

  // Read coordinate: each step bit moves one axis toward the octant's side.
  assign issue = (state_q == ST_READ) && !step_q[3];

  always_comb begin
    ax = x_q;
    ay = y_q;
    az = z_q;
    if (issue && step_q[2]) begin
      ax = oct_q[2] ? x_q + 1'b1 : x_q - 1'b1;
    end
    if (issue && step_q[1]) begin
      ay = oct_q[1] ? y_q + 1'b1 : y_q - 1'b1;
    end
    if (issue && step_q[0]) begin
      az = oct_q[0] ? z_q + 1'b1 : z_q - 1'b1;
    end
  end

  assign addr      = tlp3_pkg::cell_addr(ax, ay, az);
  assign coarse_we = (state_q == ST_DECODE) && (cmd_q == tlp3_pkg::CMD_LOAD_VALUE) && !load_oob;
  assign mask_we   = (state_q == ST_DECODE) && (cmd_q == tlp3_pkg::CMD_LOAD_MASK) && !load_oob;
  assign coarse_re = issue;
  assign mask_re   = issue && (step_q[2:0] == 3'd0);

  // Coarse memory: one access per cycle, registered read data.
  always_ff @(posedge clk_i) begin
    if (coarse_we) begin
      coarse_mem[addr] <= sample_q;
    end
    if (coarse_re) begin
      coarse_rd_q <= coarse_mem[addr];
    end
  end

  // Mask memory: written by load, read once at the center cell.
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[addr] <= mbits_q;
    end
    if (mask_re) begin
      mask_rd_q <= mask_mem[addr];
    end
  end

  // Weight travels alongside the read it belongs to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= coarse_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_weight_q <= tlp3_pkg::weight_of(step_q[2:0]);
  end

  assign mac_ctrl.clear  = (state_q == ST_DECODE);
  assign mac_ctrl.valid  = rd_vld_q;
  assign mac_ctrl.weight = rd_weight_q;

  tlp3_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .data_i   (coarse_rd_q),
    .fine_i   (sample_q),
    .result_o (mac_result)
  );

  // Size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SW'(tlp3_pkg::COARSE_SIDE);
      size_y_q <= SW'(tlp3_pkg::COARSE_SIDE);
      size_z_q <= SW'(tlp3_pkg::COARSE_SIDE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tlp3_pkg::CFG_SIZE_X: size_x_q <= cfg_data_i;
        tlp3_pkg::CFG_SIZE_Y: size_y_q <= cfg_data_i;
        tlp3_pkg::CFG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command word capture.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q    <= tlp3_pkg::cmd_e'(command_i);
      x_q      <= cell_x_i;
      y_q      <= cell_y_i;
      z_q      <= cell_z_i;
      oct_q    <= octant_i;
      sample_q <= sample_i;
      mbits_q  <= mask_bits_i;
    end
  end

  // Sequencer with registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
      status_q <= tlp3_pkg::STATUS_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          step_q   <= '0;
          result_q <= '0;
          unique case (cmd_q)
            tlp3_pkg::CMD_LOAD_VALUE, tlp3_pkg::CMD_LOAD_MASK: begin
              status_q <= load_oob ? tlp3_pkg::STATUS_RANGE : tlp3_pkg::STATUS_OK;
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
            tlp3_pkg::CMD_PROLONG: begin
              if (prolong_oob) begin
                status_q <= tlp3_pkg::STATUS_RANGE;
                done_q   <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                state_q <= ST_READ;
              end
            end
            default: begin
              status_q <= tlp3_pkg::STATUS_OK;
              done_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
          endcase
        end
        ST_READ: begin
          if (step_q == LAST_STEP) begin
            result_q <= mask_rd_q[oct_q] ? mac_result : '0;
            status_q <= tlp3_pkg::STATUS_OK;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for trilinear_prolongation_3d_unit: directed table, then random
// load/prolong traffic under several grid sizes and idle patterns. Depends on tlp3_pkg.
`timescale 1ns / 1ps

module tb;
  import tlp3_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam longint FINE_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint FINE_MIN = -FINE_MAX - 1;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_WIDTH-1:0] VAL_ONE = 32'h0001_0000;
  localparam logic [VALUE_WIDTH-1:0] VAL_NEG = 32'hFFFF_FFFF;

  // One command word and one result word.
  typedef struct packed {
    cmd_e                   cmd;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     z;
    logic [2:0]             oct;
    logic [VALUE_WIDTH-1:0] sample;
    logic [MASK_W-1:0]      mask;
  } cmd_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   status;
  } fine_word_t;

  typedef struct packed {
    cmd_word_t  word;
    logic       known;
    fine_word_t want;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = CMD_NONE;
  logic [COORD_W-1:0] cell_x_i = '0;
  logic [COORD_W-1:0] cell_y_i = '0;
  logic [COORD_W-1:0] cell_z_i = '0;
  logic [2:0] octant_i = '0;
  logic signed [VALUE_WIDTH-1:0] sample_i = '0;
  logic [MASK_W-1:0] mask_bits_i = '0;
  logic done_o;
  logic signed [VALUE_WIDTH-1:0] fine_result_o;
  logic status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_SIZE_X;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  // Shadow of the block: coarse grid, masks, which entries hold data, sizes.
  logic signed [VALUE_WIDTH-1:0] coarse_mem [STORE_DEPTH];
  logic [MASK_W-1:0] mask_mem [STORE_DEPTH];
  bit coarse_set [STORE_DEPTH];
  bit mask_set [STORE_DEPTH];
  logic [SIZE_W-1:0] size_shadow [3] = '{6'd32, 6'd32, 6'd32};

  fine_word_t fine_expected [$];
  int mismatches = 0;
  int words_sent = 0;
  int sender_idle_pct = 0;
  int stall_cycles = 0;

  // Directed words at reset sizes. Rows with known set carry their result.
  localparam int NUM_DIRECTED = 23;
  directed_row_t dir_table [NUM_DIRECTED] = '{
    // Fill the low corner around cell (1,1,1) with full scale.
    '{'{CMD_LOAD_VALUE, 6'd0, 6'd0, 6'd0, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd1, 6'd0, 6'd0, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd0, 6'd1, 6'd0, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd0, 6'd0, 6'd1, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd1, 6'd1, 6'd0, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd1, 6'd0, 6'd1, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd0, 6'd1, 6'd1, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd1, 6'd1, 6'd1, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    // Top ghost corner is writable; one past it is not.
    '{'{CMD_LOAD_VALUE, 6'd33, 6'd33, 6'd33, 3'd0, VAL_MIN, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_VALUE, 6'd34, 6'd1, 6'd1, 3'd0, VAL_ONE, 8'h00}, 1'b1,
      '{32'd0, STATUS_RANGE}},
    '{'{CMD_LOAD_MASK, 6'd63, 6'd63, 6'd63, 3'd7, VAL_NEG, 8'hFF}, 1'b1,
      '{32'd0, STATUS_RANGE}},
    '{'{CMD_LOAD_MASK, 6'd1, 6'd1, 6'd1, 3'd0, 32'd0, 8'h01}, 1'b1, '{32'd0, STATUS_OK}},
    // Full scale plus full scale saturates high.
    '{'{CMD_PROLONG, 6'd1, 6'd1, 6'd1, 3'd0, VAL_MAX, 8'h00}, 1'b1, '{VAL_MAX, STATUS_OK}},
    '{'{CMD_PROLONG, 6'd1, 6'd1, 6'd1, 3'd0, VAL_MIN, 8'h00}, 1'b0, '{32'd0, STATUS_OK}},
    // Mask bit clear gives zero with good status.
    '{'{CMD_LOAD_MASK, 6'd1, 6'd1, 6'd1, 3'd0, 32'd0, 8'hFE}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_PROLONG, 6'd1, 6'd1, 6'd1, 3'd0, VAL_ONE, 8'h00}, 1'b1, '{32'd0, STATUS_OK}},
    // Prolong on the ghost layer or beyond is flagged.
    '{'{CMD_PROLONG, 6'd0, 6'd1, 6'd1, 3'd7, VAL_ONE, 8'h00}, 1'b1, '{32'd0, STATUS_RANGE}},
    '{'{CMD_PROLONG, 6'd1, 6'd33, 6'd1, 3'd0, VAL_ONE, 8'h00}, 1'b1,
      '{32'd0, STATUS_RANGE}},
    '{'{CMD_PROLONG, 6'd1, 6'd1, 6'd63, 3'd7, VAL_NEG, 8'hFF}, 1'b1,
      '{32'd0, STATUS_RANGE}},
    // The unused command does nothing.
    '{'{CMD_NONE, 6'd63, 6'd63, 6'd63, 3'd7, VAL_NEG, 8'hFF}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_LOAD_MASK, 6'd1, 6'd1, 6'd1, 3'd7, VAL_NEG, 8'h81}, 1'b1, '{32'd0, STATUS_OK}},
    // Negative center exercises the floor shift.
    '{'{CMD_LOAD_VALUE, 6'd1, 6'd1, 6'd1, 3'd7, VAL_NEG, 8'hFF}, 1'b1, '{32'd0, STATUS_OK}},
    '{'{CMD_PROLONG, 6'd1, 6'd1, 6'd1, 3'd0, 32'd0, 8'h00}, 1'b0, '{32'd0, STATUS_OK}}
  };

  trilinear_prolongation_3d_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .octant_i      (octant_i),
    .sample_i      (sample_i),
    .mask_bits_i   (mask_bits_i),
    .done_o        (done_o),
    .fine_result_o (fine_result_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  task automatic flag_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Size registers above the interior side act as the side.
  function automatic int clip_size(logic [SIZE_W-1:0] s);
    return (int'(s) > COARSE_SIDE) ? COARSE_SIDE : int'(s);
  endfunction

  function automatic int grid_index(int x, int y, int z);
    return (x * PADDED_SIDE + y) * PADDED_SIDE + z;
  endfunction

  // Coordinate of a neighbor: moves one cell toward the octant's side when asked.
  function automatic int step_coord(int base, logic moved, logic upper);
    if (!moved) return base;
    return upper ? base + 1 : base - 1;
  endfunction

  function automatic int term_weight(int axes_moved);
    case (axes_moved)
      0:       return 27;
      1:       return 9;
      2:       return 3;
      default: return 1;
    endcase
  endfunction

  function automatic logic in_interior(cmd_word_t w);
    return w.x >= 1 && int'(w.x) <= clip_size(size_shadow[CFG_SIZE_X]) &&
           w.y >= 1 && int'(w.y) <= clip_size(size_shadow[CFG_SIZE_Y]) &&
           w.z >= 1 && int'(w.z) <= clip_size(size_shadow[CFG_SIZE_Z]);
  endfunction

  function automatic int neighbor_index(cmd_word_t w, int i);
    return grid_index(step_coord(w.x, i[2], w.oct[2]), step_coord(w.y, i[1], w.oct[1]),
                      step_coord(w.z, i[0], w.oct[0]));
  endfunction

  // True unless an in-range prolong word would touch entries that hold no data.
  function automatic logic reads_are_loaded(cmd_word_t w);
    int i;
    if (w.cmd != CMD_PROLONG || !in_interior(w)) return 1'b1;
    if (!mask_set[grid_index(w.x, w.y, w.z)]) return 1'b0;
    for (i = 0; i < 8; i++) begin
      if (!coarse_set[neighbor_index(w, i)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one command word to the shadow state and returns its result.
  function automatic fine_word_t predict_word(cmd_word_t w);
    fine_word_t r;
    int c, i;
    longint acc, total;
    r.value = '0;
    r.status = STATUS_OK;
    c = grid_index(w.x, w.y, w.z);
    case (w.cmd)
      CMD_LOAD_VALUE, CMD_LOAD_MASK: begin
        if (int'(w.x) > clip_size(size_shadow[CFG_SIZE_X]) + 1 ||
            int'(w.y) > clip_size(size_shadow[CFG_SIZE_Y]) + 1 ||
            int'(w.z) > clip_size(size_shadow[CFG_SIZE_Z]) + 1) begin
          r.status = STATUS_RANGE;
        end else if (w.cmd == CMD_LOAD_VALUE) begin
          coarse_mem[c] = w.sample;
          coarse_set[c] = 1'b1;
        end else begin
          mask_mem[c] = w.mask;
          mask_set[c] = 1'b1;
        end
      end
      CMD_PROLONG: begin
        if (!in_interior(w)) begin
          r.status = STATUS_RANGE;
        end else if (mask_mem[c][w.oct]) begin
          acc = 0;
          for (i = 0; i < 8; i++) begin
            acc += longint'(term_weight($countones(i[2:0]))) *
                   longint'(coarse_mem[neighbor_index(w, i)]);
          end
          // Arithmetic shift divides by 64 rounding toward minus infinity.
          total = longint'(signed'(w.sample)) + (acc >>> 6);
          if (total > FINE_MAX) total = FINE_MAX;
          else if (total < FINE_MIN) total = FINE_MIN;
          r.value = total[VALUE_WIDTH-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Stop sending and wait until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (fine_expected.size() != 0);
  endtask

  // Drive one word, wait for it to be taken, then idle as the phase asks.
  task automatic send_word(cmd_word_t w, logic known = 1'b0, fine_word_t given = '0);
    fine_word_t predicted;
    int gap;
    start <= 1'b1;
    command_i <= w.cmd;
    cell_x_i <= w.x;
    cell_y_i <= w.y;
    cell_z_i <= w.z;
    octant_i <= w.oct;
    sample_i <= w.sample;
    mask_bits_i <= w.mask;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = predict_word(w);
    fine_expected.push_back(known ? given : predicted);
    words_sent++;
    if (sender_idle_pct != 0 && $urandom_range(49) == 0) begin
      wait_drained();
    end else begin
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Writes all three size registers; the block must be idle.
  task automatic set_sizes(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                           logic [SIZE_W-1:0] sz);
    cfg_idx_e regs [3];
    logic [SIZE_W-1:0] vals [3];
    int i;
    regs = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z};
    vals = '{sx, sy, sz};
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      size_shadow[regs[i]] = vals[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cmd_word_t make_word(cmd_e cmd, int x, int y, int z, logic [2:0] oct,
                                          logic [VALUE_WIDTH-1:0] sample,
                                          logic [MASK_W-1:0] mask);
    cmd_word_t w;
    w.cmd = cmd;
    w.x = COORD_W'(x);
    w.y = COORD_W'(y);
    w.z = COORD_W'(z);
    w.oct = oct;
    w.sample = sample;
    w.mask = mask;
    return w;
  endfunction

  // Values lean toward full scale, zero and minus one so saturation shows up.
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return VAL_NEG;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a small corner of the grid so that loaded entries get reused.
  function automatic int pick_interior(int s);
    if ($urandom_range(9) < 7) return $urandom_range((s < 3) ? s : 3, 1);
    return $urandom_range(s, 1);
  endfunction

  function automatic int noise_coord(int s);
    if ($urandom_range(1) != 0) return $urandom_range(63, 0);
    return $urandom_range(s + 2, 0);
  endfunction

  // Load whatever a prolong needs, sometimes reload it, then prolong.
  task automatic prolong_sequence();
    cmd_word_t p;
    logic [MASK_W-1:0] m;
    int c, i;
    p = make_word(CMD_PROLONG, pick_interior(clip_size(size_shadow[CFG_SIZE_X])),
                  pick_interior(clip_size(size_shadow[CFG_SIZE_Y])),
                  pick_interior(clip_size(size_shadow[CFG_SIZE_Z])),
                  3'($urandom()), pick_value(), 8'($urandom()));
    c = grid_index(p.x, p.y, p.z);
    if (!mask_set[c] || $urandom_range(9) < 3) begin
      m = 8'($urandom());
      if ($urandom_range(1) != 0) m[p.oct] = 1'b1;
      send_word(make_word(CMD_LOAD_MASK, p.x, p.y, p.z, 3'($urandom()), $urandom(), m));
    end
    for (i = 0; i < 8; i++) begin
      c = neighbor_index(p, i);
      if (!coarse_set[c] || $urandom_range(9) < 2) begin
        send_word(make_word(CMD_LOAD_VALUE, step_coord(p.x, i[2], p.oct[2]),
                            step_coord(p.y, i[1], p.oct[1]), step_coord(p.z, i[0], p.oct[0]),
                            3'($urandom()), pick_value(), 8'($urandom())));
      end
    end
    send_word(p);
  endtask

  // Any command with loose coordinates; prolongs that would touch empty entries are dropped.
  task automatic noise_word();
    cmd_word_t w;
    w = make_word(cmd_e'($urandom_range(3)),
                  noise_coord(clip_size(size_shadow[CFG_SIZE_X])),
                  noise_coord(clip_size(size_shadow[CFG_SIZE_Y])),
                  noise_coord(clip_size(size_shadow[CFG_SIZE_Z])),
                  3'($urandom()), pick_value(), 8'($urandom()));
    if (reads_are_loaded(w)) send_word(w);
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                           logic [SIZE_W-1:0] sz, int idle_pct, int count);
    int stop_at;
    wait_drained();
    set_sizes(sx, sy, sz);
    sender_idle_pct = idle_pct;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if (clip_size(size_shadow[CFG_SIZE_X]) > 0 && clip_size(size_shadow[CFG_SIZE_Y]) > 0 &&
          clip_size(size_shadow[CFG_SIZE_Z]) > 0 && $urandom_range(99) < 75) begin
        prolong_sequence();
      end else begin
        noise_word();
      end
    end
  endtask

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    fine_word_t want;
    if (rst_ni && done_o) begin
      if (fine_expected.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = fine_expected.pop_front();
        if (fine_result_o !== want.value) begin
          flag_mismatch($sformatf("fine_result %h, wanted %h", fine_result_o, want.value));
        end
        if (status_o !== want.status) begin
          flag_mismatch($sformatf("status %b, wanted %b", status_o, want.status));
        end
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_word(dir_table[i].word, dir_table[i].known, dir_table[i].want);
    end
    run_phase(6'd4, 6'd5, 6'd3, 0, 100);
    run_phase(6'd1, 6'd1, 6'd1, 88, 60);
    run_phase(6'd63, 6'd33, 6'd32, 28, 110);
    run_phase(6'd0, 6'd2, 6'd7, 88, 60);
    run_phase(6'd6, 6'd32, 6'd2, 0, 120);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fine_expected.size() != 0) flag_mismatch("results still outstanding at the end");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tlp3_pkg.sv
hdl/tlp3_mac.sv
hdl/trilinear_prolongation_3d_unit.sv
tb/tb.sv
